[hw/rtl/erl_pkg.sv]
// ----------------------------------------------------------------------------
// erl_pkg
// Shared types and constants for the event ring log with recent readout.
// ----------------------------------------------------------------------------
package erl_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned KIND_W  = 8;
  localparam int unsigned STAMP_W = 64;
  localparam int unsigned WANT_W  = 7;
  localparam int unsigned KC_W    = 9;

  localparam logic [KC_W-1:0] KIND_COUNT_RST = 9'd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_EVAL,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [STAMP_W-1:0] stamp;
  } rec_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

endpackage

[hw/rtl/erl_if.sv]
// ----------------------------------------------------------------------------
// erl_if
// Channel interfaces: command input, result output and kind_count write.
// ----------------------------------------------------------------------------
interface erl_in_if;
  logic                                valid;
  logic                                ready;
  logic [erl_pkg::CMD_W-1:0]           cmd;
  logic [erl_pkg::KIND_W-1:0]          kind;
  logic signed [erl_pkg::STAMP_W-1:0]  timestamp;
  logic [erl_pkg::WANT_W-1:0]          want;

  modport source (output valid, cmd, kind, timestamp, want, input ready);
  modport sink   (input valid, cmd, kind, timestamp, want, output ready);
endinterface

interface erl_out_if #(
  parameter int unsigned CNT_W = 9
);
  logic                                valid;
  logic                                ready;
  logic                                status;
  logic                                has_record;
  logic [erl_pkg::KIND_W-1:0]          rec_kind;
  logic signed [erl_pkg::STAMP_W-1:0]  rec_time;
  logic [CNT_W-1:0]                    stored_count;
  logic                                last;

  modport source (output valid, status, has_record, rec_kind, rec_time, stored_count, last,
                  input ready);
  modport sink   (input valid, status, has_record, rec_kind, rec_time, stored_count, last,
                  output ready);
endinterface

interface erl_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [erl_pkg::KC_W-1:0]    kind_count;

  modport source (output valid, kind_count, input ready);
  modport sink   (input valid, kind_count, output ready);
endinterface

[hw/rtl/erl_store.sv]
// ----------------------------------------------------------------------------
// erl_store
// Record memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module erl_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                clk,
  input  erl_pkg::store_ctl_t ctl,
  input  logic [AW-1:0]       wr_addr,
  input  erl_pkg::rec_t       wr_rec,
  input  logic [AW-1:0]       rd_addr,
  output erl_pkg::rec_t       rd_rec
);

  erl_pkg::rec_t mem [DEPTH];
  erl_pkg::rec_t rd_rec_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_rec_r <= mem[rd_addr];
    end
  end

  assign rd_rec = rd_rec_r;

endmodule

[hw/rtl/event_ring_log_recent_readout.sv]
// ----------------------------------------------------------------------------
// event_ring_log_recent_readout
// Circular event trace store with a newest-first readout of recent records.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  in_ch    in   valid / ready    cmd, kind, timestamp, want
//  out_ch   out  valid / ready    status, has_record, rec_kind, rec_time,
//                                 stored_count, last
//  cfg_ch   in   valid / ready    kind_count (ready always high)
//
//  Append, clear and unused codes each give one item.
//  A read visits each record in an address state (ISSUE) and a compare
//  state (EVAL), both on the single store read port.
//  One record is held back so last can be set on the final emitted one.
//  Reset clears sequencer, head, count, idx, left and valid flags and sets kind_count to 256 only.
//  A full output register stalls the sequencer; input waits until idle with the output free.
// ----------------------------------------------------------------------------
module event_ring_log_recent_readout #(
  parameter int unsigned CAPACITY  = 256,
  parameter int unsigned SLICE_MAX = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  erl_in_if.sink        in_ch,
  erl_out_if.source     out_ch,
  erl_cfg_if.sink       cfg_ch
);

  localparam int unsigned AW     = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned LEN_W  = $clog2(SLICE_MAX + 1);
  localparam int unsigned CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int unsigned WCMP_W = (erl_pkg::WANT_W > LEN_W) ? erl_pkg::WANT_W : LEN_W;

  erl_pkg::state_t state_r, state_nxt;

  logic [erl_pkg::KC_W-1:0] kind_count_r;
  logic [AW-1:0]            head_r, head_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [AW-1:0]            idx_r;
  logic [LEN_W-1:0]         left_r;
  logic                     pend_valid_r;
  erl_pkg::rec_t            pend_rec_r;

  logic                     out_valid_r;
  logic                     out_status_r;
  logic                     out_has_r;
  erl_pkg::rec_t            out_rec_r;
  logic [CNT_W-1:0]         out_cnt_r;
  logic                     out_last_r;

  logic                     out_free, in_ready, in_fire;
  erl_pkg::cmd_t            cmd;
  logic [erl_pkg::KIND_W-1:0] cmp_kind;
  logic                     kind_ok;
  logic [AW-1:0]            idx_prev;
  logic [LEN_W-1:0]         want_cl, rd_len;
  logic [CMP_W-1:0]         rd_len_w;

  erl_pkg::store_ctl_t      ctl;
  erl_pkg::rec_t            wr_rec, rd_rec;

  logic                     out_load, ld_status, ld_has, ld_last, pend_load;
  erl_pkg::rec_t            ld_rec;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ready = (state_r == erl_pkg::S_IDLE) && out_free;
  assign in_fire  = in_ch.valid && in_ready;
  assign cmd      = erl_pkg::cmd_t'(in_ch.cmd);

  // shared kind compare: input kind while idle, fetched kind during a walk
  assign cmp_kind = (state_r == erl_pkg::S_IDLE) ? in_ch.kind : rd_rec.kind;
  assign kind_ok  = {1'b0, cmp_kind} < kind_count_r;

  assign idx_prev = (idx_r == '0) ? AW'(CAPACITY - 1) : idx_r - 1'b1;

  always_comb begin
    if (WCMP_W'(in_ch.want) > WCMP_W'(SLICE_MAX)) begin
      want_cl = LEN_W'(SLICE_MAX);
    end else begin
      want_cl = LEN_W'(in_ch.want);
    end
    if (CMP_W'(want_cl) > CMP_W'(cnt_r)) begin
      rd_len_w = CMP_W'(cnt_r);
    end else begin
      rd_len_w = CMP_W'(want_cl);
    end
    rd_len = LEN_W'(rd_len_w);
  end

  assign wr_rec.kind  = in_ch.kind;
  assign wr_rec.stamp = in_ch.timestamp;

  // head and count update
  always_comb begin
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    if (in_fire) begin
      if (cmd == erl_pkg::CMD_APPEND && kind_ok) begin
        head_nxt = (head_r == AW'(CAPACITY - 1)) ? '0 : head_r + 1'b1;
        if (cnt_r != CNT_W'(CAPACITY)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end else if (cmd == erl_pkg::CMD_CLEAR) begin
        head_nxt = '0;
        cnt_nxt  = '0;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      erl_pkg::S_IDLE: begin
        if (in_fire && cmd == erl_pkg::CMD_READ && rd_len != '0) begin
          state_nxt = erl_pkg::S_ISSUE;
        end
      end
      erl_pkg::S_ISSUE: begin
        state_nxt = erl_pkg::S_EVAL;
      end
      erl_pkg::S_EVAL: begin
        if (!(kind_ok && pend_valid_r && !out_free)) begin
          state_nxt = (left_r == '0) ? erl_pkg::S_FLUSH : erl_pkg::S_ISSUE;
        end
      end
      erl_pkg::S_FLUSH: begin
        if (out_free) begin
          state_nxt = erl_pkg::S_IDLE;
        end
      end
      default: state_nxt = erl_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    out_load  = 1'b0;
    ld_status = 1'b0;
    ld_has    = 1'b0;
    ld_rec    = '0;
    ld_last   = 1'b1;
    pend_load = 1'b0;
    ctl       = '0;
    unique case (state_r)
      erl_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (cmd)
            erl_pkg::CMD_APPEND: begin
              out_load   = 1'b1;
              ld_status  = !kind_ok;
              ctl.wr_en  = kind_ok;
            end
            erl_pkg::CMD_READ: begin
              out_load = (rd_len == '0);
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      erl_pkg::S_ISSUE: begin
        ctl.rd_en = 1'b1;
      end
      erl_pkg::S_EVAL: begin
        if (kind_ok) begin
          if (pend_valid_r) begin
            if (out_free) begin
              out_load  = 1'b1;
              ld_has    = 1'b1;
              ld_rec    = pend_rec_r;
              ld_last   = 1'b0;
              pend_load = 1'b1;
            end
          end else begin
            pend_load = 1'b1;
          end
        end
      end
      erl_pkg::S_FLUSH: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_has   = pend_valid_r;
          ld_rec   = pend_valid_r ? pend_rec_r : '0;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  erl_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .ctl     (ctl),
    .wr_addr (head_r),
    .wr_rec  (wr_rec),
    .rd_addr (idx_prev),
    .rd_rec  (rd_rec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= erl_pkg::S_IDLE;
      kind_count_r <= erl_pkg::KIND_COUNT_RST;
      head_r       <= '0;
      cnt_r        <= '0;
      idx_r        <= '0;
      left_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_ch.valid) begin
        kind_count_r <= cfg_ch.kind_count;
      end
      if (in_fire && cmd == erl_pkg::CMD_READ) begin
        idx_r        <= head_r;
        left_r       <= rd_len;
        pend_valid_r <= 1'b0;
      end else if (state_r == erl_pkg::S_ISSUE) begin
        idx_r  <= idx_prev;
        left_r <= left_r - 1'b1;
      end
      if (pend_load) begin
        pend_valid_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend_rec_r <= rd_rec;
    end
    if (out_load) begin
      out_status_r <= ld_status;
      out_has_r    <= ld_has;
      out_rec_r    <= ld_rec;
      out_cnt_r    <= cnt_nxt;
      out_last_r   <= ld_last;
    end
  end

  assign in_ch.ready         = in_ready;
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.has_record   = out_has_r;
  assign out_ch.rec_kind     = out_rec_r.kind;
  assign out_ch.rec_time     = out_rec_r.stamp;
  assign out_ch.stored_count = out_cnt_r;
  assign out_ch.last         = out_last_r;

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= AW'(CAPACITY - 1))
    else $error("head out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result loaded over a pending item");

  a_left_max: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= LEN_W'(SLICE_MAX))
    else $error("walk length above slice maximum");

  a_eval_order: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == erl_pkg::S_EVAL) |-> $past(state_r) == erl_pkg::S_ISSUE)
    else $error("compare step without a fetch");

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the event ring log with newest-first readout.
// Commands are driven from a queue and predicted on acceptance. Results are
// checked field by field in order. kind_count is changed between phases, and
// both channels see random stalls plus one long output hold.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [erl_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int unsigned      LOG_DEPTH  = 256;
  localparam int unsigned      READ_MAX   = 16;
  localparam int unsigned      QUIET_MAX  = 3000;
  localparam int unsigned      LONG_HOLD  = 80;
  localparam logic [63:0]      STAMP_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [63:0]      STAMP_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [erl_pkg::CMD_W-1:0]   cmd;
    logic [erl_pkg::KIND_W-1:0]  kind;
    logic [erl_pkg::STAMP_W-1:0] stamp;
    logic [erl_pkg::WANT_W-1:0]  want;
  } log_req_t;

  typedef struct {
    logic                        status;
    logic                        has_record;
    logic [erl_pkg::KIND_W-1:0]  rec_kind;
    logic [erl_pkg::STAMP_W-1:0] rec_time;
    logic [erl_pkg::KC_W-1:0]    stored_count;
    logic                        last;
  } log_rsp_t;

  logic clk;
  logic rst_n;

  erl_in_if              in_ch ();
  erl_out_if #(.CNT_W(9)) out_ch ();
  erl_cfg_if             cfg_ch ();

  event_ring_log_recent_readout i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  log_req_t pending_reqs[$];
  log_rsp_t expected_rsps[$];

  // predicted log contents
  logic [erl_pkg::KIND_W-1:0]  kind_mem [LOG_DEPTH];
  logic [erl_pkg::STAMP_W-1:0] time_mem [LOG_DEPTH];
  logic [7:0]                  head;
  logic [erl_pkg::KC_W-1:0]    held;
  logic [erl_pkg::KC_W-1:0]    kind_lim;

  bit gaps_on;
  int send_gap;
  int hold_left;
  int long_hold_reqs;
  int long_hold_done;
  int mismatch_cnt;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic predict_trace_rsps(input log_req_t req);
    log_rsp_t   rsp;
    int         n;
    int         found;
    logic [7:0] idx;
    rsp   = '{default: '0};
    found = 0;
    case (req.cmd)
      erl_pkg::CMD_APPEND: begin
        if ({1'b0, req.kind} >= kind_lim) begin
          rsp.status = 1'b1;
        end else begin
          kind_mem[head] = req.kind;
          time_mem[head] = req.stamp;
          head = head + 8'd1;
          if (held < LOG_DEPTH) held = held + 9'd1;
        end
      end
      erl_pkg::CMD_READ: begin
        n = int'(req.want);
        if (n > READ_MAX) n = READ_MAX;
        if (n > held) n = int'(held);
        idx = head;
        for (int i = 0; i < n; i++) begin
          idx = idx - 8'd1;
          if ({1'b0, kind_mem[idx]} < kind_lim) begin
            rsp.has_record   = 1'b1;
            rsp.rec_kind     = kind_mem[idx];
            rsp.rec_time     = time_mem[idx];
            rsp.stored_count = held;
            rsp.last         = 1'b0;
            expected_rsps.push_back(rsp);
            found++;
          end
        end
      end
      erl_pkg::CMD_CLEAR: begin
        head = 8'd0;
        held = 9'd0;
      end
      default: ;
    endcase
    if (found > 0) begin
      expected_rsps[expected_rsps.size()-1].last = 1'b1;
    end else begin
      rsp = '{default: '0};
      rsp.status       = (req.cmd == erl_pkg::CMD_APPEND) && ({1'b0, req.kind} >= kind_lim);
      rsp.stored_count = held;
      rsp.last         = 1'b1;
      expected_rsps.push_back(rsp);
    end
  endtask

  // command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_trace_rsps(pending_reqs.pop_front());
        if (gaps_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 10);
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered item
      end else if (send_gap != 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= pending_reqs[0].cmd;
        in_ch.kind      <= pending_reqs[0].kind;
        in_ch.timestamp <= pending_reqs[0].stamp;
        in_ch.want      <= pending_reqs[0].want;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor and output stalls
  always @(posedge clk) begin
    log_rsp_t exp_rsp;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt < 40)
            $display("%0t: unexpected item: st %0b rec %0b kind %0h time %0h cnt %0d last %0b",
                     $time, out_ch.status, out_ch.has_record, out_ch.rec_kind,
                     out_ch.rec_time, out_ch.stored_count, out_ch.last);
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (out_ch.status !== exp_rsp.status || out_ch.has_record !== exp_rsp.has_record ||
              out_ch.rec_kind !== exp_rsp.rec_kind || out_ch.rec_time !== exp_rsp.rec_time ||
              out_ch.stored_count !== exp_rsp.stored_count || out_ch.last !== exp_rsp.last) begin
            mismatch_cnt++;
            if (mismatch_cnt < 40) begin
              $display("%0t: mismatch exp: st %0b rec %0b kind %0h time %0h cnt %0d last %0b",
                       $time, exp_rsp.status, exp_rsp.has_record, exp_rsp.rec_kind,
                       exp_rsp.rec_time, exp_rsp.stored_count, exp_rsp.last);
              $display("%0t: mismatch act: st %0b rec %0b kind %0h time %0h cnt %0d last %0b",
                       $time, out_ch.status, out_ch.has_record, out_ch.rec_kind,
                       out_ch.rec_time, out_ch.stored_count, out_ch.last);
            end
          end
        end
      end
      if (long_hold_done != long_hold_reqs) begin
        long_hold_done++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 9);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_MAX) begin
      $display("watchdog: no handshake for %0d cycles at %0t", quiet_cycles, $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_ch.valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_kind_count(input logic [erl_pkg::KC_W-1:0] value);
    cfg_ch.kind_count <= value;
    cfg_ch.valid      <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    kind_lim = value;
    @(posedge clk);
  endtask

  function automatic log_req_t make_req(input logic [erl_pkg::CMD_W-1:0]   cmd,
                                        input logic [erl_pkg::KIND_W-1:0]  kind,
                                        input logic [erl_pkg::STAMP_W-1:0] stamp,
                                        input logic [erl_pkg::WANT_W-1:0]  want);
    log_req_t req;
    req.cmd   = cmd;
    req.kind  = kind;
    req.stamp = stamp;
    req.want  = want;
    return req;
  endfunction

  function automatic log_req_t rand_req(input int append_pct, input int clear_pct);
    log_req_t req;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < append_pct) req.cmd = erl_pkg::CMD_APPEND;
    else if (pick < append_pct + clear_pct) req.cmd = erl_pkg::CMD_CLEAR;
    else if (pick < append_pct + clear_pct + 2) req.cmd = CMD_SPARE;
    else req.cmd = erl_pkg::CMD_READ;
    req.kind = ($urandom_range(0, 3) == 0) ? erl_pkg::KIND_W'($urandom_range(0, 3))
                                           : erl_pkg::KIND_W'($urandom_range(0, 255));
    case ($urandom_range(0, 15))
      0:       req.stamp = STAMP_MIN;
      1:       req.stamp = STAMP_MAX;
      2:       req.stamp = '1;
      default: req.stamp = {$urandom, $urandom};
    endcase
    req.want = ($urandom_range(0, 7) == 0) ? erl_pkg::WANT_W'($urandom_range(0, 127))
                                           : erl_pkg::WANT_W'($urandom_range(0, 20));
    return req;
  endfunction

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = erl_pkg::CMD_APPEND;
    in_ch.kind        = '0;
    in_ch.timestamp   = '0;
    in_ch.want        = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.kind_count = erl_pkg::KIND_COUNT_RST;
    head              = 8'd0;
    held              = 9'd0;
    kind_lim          = erl_pkg::KIND_COUNT_RST;
    gaps_on           = 1'b1;
    long_hold_reqs    = 0;
    long_hold_done    = 0;
    mismatch_cnt      = 0;
    quiet_cycles      = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty log, extremes, clamping, clear
    write_kind_count(9'd256);
    pending_reqs.push_back(make_req(erl_pkg::CMD_READ,   8'h00, 64'd0, 7'd5));
    pending_reqs.push_back(make_req(CMD_SPARE,           8'hFF, '1, 7'd127));
    pending_reqs.push_back(make_req(erl_pkg::CMD_APPEND, 8'h00, STAMP_MIN, 7'd0));
    pending_reqs.push_back(make_req(erl_pkg::CMD_APPEND, 8'hFF, STAMP_MAX, 7'd0));
    pending_reqs.push_back(make_req(erl_pkg::CMD_APPEND, 8'h55, '1, 7'd0));
    pending_reqs.push_back(make_req(erl_pkg::CMD_APPEND, 8'hAA, 64'd0, 7'd0));
    pending_reqs.push_back(make_req(erl_pkg::CMD_READ,   8'h00, 64'd0, 7'd0));
    pending_reqs.push_back(make_req(erl_pkg::CMD_READ,   8'h00, 64'd0, 7'd3));
    pending_reqs.push_back(make_req(erl_pkg::CMD_READ,   8'h00, 64'd0, 7'd127));
    pending_reqs.push_back(make_req(erl_pkg::CMD_CLEAR,  8'h00, 64'd0, 7'd0));
    pending_reqs.push_back(make_req(erl_pkg::CMD_READ,   8'h00, 64'd0, 7'd4));
    pending_reqs.push_back(make_req(erl_pkg::CMD_APPEND, 8'h7F, 64'd1, 7'd0));
    pending_reqs.push_back(make_req(erl_pkg::CMD_APPEND, 8'h80, 64'h5555_5555_5555_5555,
                                    7'd0));
    pending_reqs.push_back(make_req(erl_pkg::CMD_APPEND, 8'h01, 64'hAAAA_AAAA_AAAA_AAAA,
                                    7'd0));
    wait_drained();

    // no kind valid
    write_kind_count(9'd0);
    pending_reqs.push_back(make_req(erl_pkg::CMD_APPEND, 8'h00, 64'd7, 7'd0));
    pending_reqs.push_back(make_req(erl_pkg::CMD_READ,   8'h00, 64'd0, 7'd16));
    wait_drained();

    // only kind 0 valid
    write_kind_count(9'd1);
    pending_reqs.push_back(make_req(erl_pkg::CMD_APPEND, 8'h00, 64'd9, 7'd0));
    pending_reqs.push_back(make_req(erl_pkg::CMD_APPEND, 8'h01, 64'd10, 7'd0));
    pending_reqs.push_back(make_req(erl_pkg::CMD_READ,   8'h00, 64'd0, 7'd16));
    pending_reqs.push_back(make_req(erl_pkg::CMD_READ,   8'h00, 64'd0, 7'd1));
    wait_drained();

    // fill past capacity so the head wraps; long output hold at the start
    write_kind_count(9'd256);
    long_hold_reqs++;
    for (int i = 0; i < 145; i++) pending_reqs.push_back(rand_req(90, 0));
    wait_drained();
    for (int i = 0; i < 145; i++) pending_reqs.push_back(rand_req(90, 0));
    wait_drained();

    gaps_on = 1'b0;
    write_kind_count(9'd1);
    for (int i = 0; i < 25; i++) pending_reqs.push_back(rand_req(40, 0));
    wait_drained();

    gaps_on = 1'b1;
    write_kind_count(9'd100);
    for (int i = 0; i < 40; i++) pending_reqs.push_back(rand_req(50, 4));
    wait_drained();

    gaps_on = 1'b0;
    write_kind_count(9'd511);
    for (int i = 0; i < 40; i++) pending_reqs.push_back(rand_req(50, 4));
    wait_drained();

    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0 && expected_rsps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
